/* design/bank_class_histogram_assert.svh */
// assertion macros for the top-level design file
`ifndef BANK_CLASS_HISTOGRAM_ASSERT_SVH
`define BANK_CLASS_HISTOGRAM_ASSERT_SVH

// same-cycle implication
`define BCH_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bank_class_histogram check failed");

// next-cycle implication
`define BCH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bank_class_histogram check failed");

`endif

/* design/bch_pkg.sv */
package bch_pkg;

	localparam int MAX_CLASSES = 64;
	localparam int SLOT_W      = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int ENTRY_W     = 7;
	localparam int KEY_W       = 32;
	localparam int ADD_W       = 32;
	localparam int CNT_W       = 48;

	typedef struct packed {
		logic [KEY_W-1:0] class_key;
		logic [ADD_W-1:0] pages_add;
		logic [CNT_W-1:0] bytes_add;
	} bch_item_t;

	typedef struct packed {
		logic               status;
		logic [ENTRY_W-1:0] entries_used;
		logic [CNT_W-1:0]   class_pages;
		logic [CNT_W-1:0]   class_bytes;
		logic [CNT_W-1:0]   pages_total;
		logic [KEY_W-1:0]   top_class;
		logic [CNT_W-1:0]   top_pages;
	} bch_result_t;

	typedef struct packed {
		logic start;
		logic search;
		logic fetch;
		logic calc;
		logic commit;
	} bch_cmd_t;

	typedef struct packed {
		logic hit;
		logic exhausted;
		logic out_free;
	} bch_sts_t;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

endpackage

/* design/bch_ctrl.sv */
module bch_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  bch_pkg::bch_sts_t sts,
	output bch_pkg::bch_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_FETCH,
		ST_CALC,
		ST_COMMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_valid) state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (sts.hit || sts.exhausted) state_q <= ST_FETCH;
				end
				ST_FETCH: state_q <= ST_CALC;
				ST_CALC: state_q <= ST_COMMIT;
				ST_COMMIT: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign item_stall = (state_q != ST_IDLE);
	assign cmd.start  = (state_q == ST_IDLE) && item_valid;
	assign cmd.search = (state_q == ST_SEARCH);
	assign cmd.fetch  = (state_q == ST_FETCH);
	assign cmd.calc   = (state_q == ST_CALC);
	assign cmd.commit = (state_q == ST_COMMIT) && sts.out_free;

endmodule

/* design/bch_dp.sv */
module bch_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bch_pkg::bch_cmd_t    cmd,
	output bch_pkg::bch_sts_t    sts,
	input  bch_pkg::bch_item_t   item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output bch_pkg::bch_result_t result
);

	logic [bch_pkg::KEY_W-1:0] key_mem  [bch_pkg::MAX_CLASSES];
	logic [bch_pkg::CNT_W-1:0] page_mem [bch_pkg::MAX_CLASSES];
	logic [bch_pkg::CNT_W-1:0] byte_mem [bch_pkg::MAX_CLASSES];

	bch_pkg::bch_item_t          item_q;
	logic [bch_pkg::ENTRY_W-1:0] idx_q;
	logic                        rv_s1;
	logic [bch_pkg::KEY_W-1:0]   rkey_s1;
	logic [bch_pkg::SLOT_W-1:0]  ridx_s1;
	logic                        found_q;
	logic [bch_pkg::SLOT_W-1:0]  slot_q;
	logic [bch_pkg::CNT_W-1:0]   rpage_q;
	logic [bch_pkg::CNT_W-1:0]   rbyte_q;
	logic [bch_pkg::CNT_W-1:0]   newp_q;
	logic [bch_pkg::CNT_W-1:0]   newb_q;
	logic [bch_pkg::CNT_W-1:0]   sumn_q;
	logic [bch_pkg::ENTRY_W-1:0] fill_q;
	logic [bch_pkg::CNT_W-1:0]   sum_q;
	logic [bch_pkg::KEY_W-1:0]   lead_key_q;
	logic [bch_pkg::CNT_W-1:0]   lead_pages_q;
	logic [bch_pkg::SLOT_W-1:0]  lead_slot_q;
	logic                        out_valid_q;
	bch_pkg::bch_result_t        out_q;

	logic                        hit;
	logic                        zero_add;
	logic                        full;
	logic                        touched;
	logic                        beat;
	logic [bch_pkg::SLOT_W-1:0]  wslot;
	logic [bch_pkg::CNT_W-1:0]   padd_ext;
	logic [bch_pkg::ENTRY_W-1:0] fill_next;
	logic                        write_en;

	assign hit       = rv_s1 && (rkey_s1 == item_q.class_key);
	assign zero_add  = (item_q.pages_add == '0) && (item_q.bytes_add == '0);
	assign full      = (fill_q >= bch_pkg::ENTRY_W'(bch_pkg::MAX_CLASSES));
	assign touched   = !zero_add && (found_q || !full);
	assign wslot     = found_q ? slot_q : fill_q[bch_pkg::SLOT_W-1:0];
	assign padd_ext  = bch_pkg::CNT_W'(item_q.pages_add);
	assign fill_next = (touched && !found_q) ? fill_q + 1'b1 : fill_q;
	assign write_en  = cmd.commit && touched;
	assign beat      = (newp_q > lead_pages_q) ||
		((newp_q != '0) && (newp_q == lead_pages_q) && (wslot < lead_slot_q));

	assign sts.hit       = hit;
	assign sts.exhausted = !rv_s1 && (idx_q >= fill_q);
	assign sts.out_free  = !out_valid_q || !result_stall;

	// stores
	always_ff @(posedge clk) begin
		if (cmd.search) rkey_s1 <= key_mem[idx_q[bch_pkg::SLOT_W-1:0]];
		if (write_en && !found_q) key_mem[wslot] <= item_q.class_key;
	end

	always_ff @(posedge clk) begin
		if (cmd.fetch) rpage_q <= page_mem[slot_q];
		if (write_en) page_mem[wslot] <= newp_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.fetch) rbyte_q <= byte_mem[slot_q];
		if (write_en) byte_mem[wslot] <= newb_q;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) item_q <= item;
		if (cmd.search) ridx_s1 <= idx_q[bch_pkg::SLOT_W-1:0];
		if (cmd.search && hit) slot_q <= ridx_s1;
		if (cmd.calc) begin
			newp_q <= found_q ? bch_pkg::sat_add(rpage_q, padd_ext) : padd_ext;
			newb_q <= found_q ? bch_pkg::sat_add(rbyte_q, item_q.bytes_add)
				: item_q.bytes_add;
			sumn_q <= bch_pkg::sat_add(sum_q, padd_ext);
		end
		if (cmd.commit) begin
			out_q.status       <= !zero_add && !found_q && full;
			out_q.entries_used <= fill_next;
			out_q.class_pages  <= touched ? newp_q : ((zero_add && found_q) ? rpage_q : '0);
			out_q.class_bytes  <= touched ? newb_q : ((zero_add && found_q) ? rbyte_q : '0);
			out_q.pages_total  <= touched ? sumn_q : sum_q;
			out_q.top_class    <= (touched && beat) ? item_q.class_key : lead_key_q;
			out_q.top_pages    <= (touched && beat) ? newp_q : lead_pages_q;
		end
	end

	// control and running totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			rv_s1        <= 1'b0;
			found_q      <= 1'b0;
			fill_q       <= '0;
			sum_q        <= '0;
			lead_key_q   <= '0;
			lead_pages_q <= '0;
			lead_slot_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.start) begin
				idx_q   <= '0;
				rv_s1   <= 1'b0;
				found_q <= 1'b0;
			end else if (cmd.search) begin
				if (hit) found_q <= 1'b1;
				if (idx_q < fill_q) begin
					rv_s1 <= 1'b1;
					idx_q <= idx_q + 1'b1;
				end else begin
					rv_s1 <= 1'b0;
				end
			end
			if (write_en) begin
				fill_q <= fill_next;
				sum_q  <= sumn_q;
				if (beat) begin
					lead_key_q   <= item_q.class_key;
					lead_pages_q <= newp_q;
					lead_slot_q  <= wslot;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

/* design/bank_class_histogram.sv */
// bank class histogram
// item channel: item_valid / item_stall with the item struct (class key, page
// count, byte count). one transaction in gives exactly one result transaction
// on result_valid / result_stall with status, entry count, class counts, page
// total and the dominant class.
// after acceptance the item passes through the search, fetch, calc and commit
// states; the search reads one stored key per cycle from the key memory and
// ends on a hit or when every stored entry has been compared.
// item_stall is high from the acceptance edge until the result is loaded into
// the output register; the next item may be taken while that result waits.
// a stalled result holds; an item finishing behind it waits in its last step.
// reset empties the table, clears the total and the dominant class and drops
// any pending result; no clearing pass is needed.
module bank_class_histogram (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  bch_pkg::bch_item_t   item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output bch_pkg::bch_result_t result
);

	bch_pkg::bch_cmd_t cmd;
	bch_pkg::bch_sts_t sts;

	bch_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	bch_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`include "bank_class_histogram_assert.svh"

	`BCH_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall)
	`BCH_ASSERT_NOW(a_fill_bound, result_valid,
		result.entries_used <= bch_pkg::ENTRY_W'(bch_pkg::MAX_CLASSES))
	`BCH_ASSERT_NOW(a_full_status, result_valid && result.status,
		result.entries_used == bch_pkg::ENTRY_W'(bch_pkg::MAX_CLASSES))
	`BCH_ASSERT_NOW(a_top_le_total, result_valid, result.top_pages <= result.pages_total)

endmodule

/* dv/bank_class_histogram_checker.sv */
`timescale 1ns / 100ps
module bank_class_histogram_checker
	import bch_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_stall,
	input  bch_item_t   item,
	input  logic        result_valid,
	input  logic        result_stall,
	input  bch_result_t result,
	output int          fails,
	output int          pending
);

	localparam logic ST_OK         = 1'b0;
	localparam logic ST_TABLE_FULL = 1'b1;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// shadow of the class table
	logic [KEY_W-1:0] keys_held  [MAX_CLASSES];
	logic [CNT_W-1:0] pages_held [MAX_CLASSES];
	logic [CNT_W-1:0] bytes_held [MAX_CLASSES];
	int unsigned      used;
	logic [CNT_W-1:0] total;
	logic [KEY_W-1:0] lead_key;
	logic [CNT_W-1:0] lead_pages;
	int unsigned      lead_slot;

	bch_result_t due_results [$];
	bch_result_t want;

	function automatic logic [CNT_W-1:0] clamp_add(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		if (a > CNT_MAX - b)
			return CNT_MAX;
		return a + b;
	endfunction

	// applies one transaction to the shadow table and returns its result
	function automatic bch_result_t tally(input bch_item_t it);
		bch_result_t      r;
		int unsigned      slot;
		bit               hit;
		bit               touched;
		logic [CNT_W-1:0] padd;
		logic [CNT_W-1:0] badd;
		r       = '0;
		slot    = 0;
		hit     = 1'b0;
		touched = 1'b0;
		padd    = CNT_W'(it.pages_add);
		badd    = it.bytes_add;
		for (int unsigned i = 0; i < used; i++) begin
			if (!hit && keys_held[i] == it.class_key) begin
				hit  = 1'b1;
				slot = i;
			end
		end
		r.status = ST_OK;
		if (padd == '0 && badd == '0) begin
			if (hit) begin
				r.class_pages = pages_held[slot];
				r.class_bytes = bytes_held[slot];
			end
		end else if (hit) begin
			pages_held[slot] = clamp_add(pages_held[slot], padd);
			bytes_held[slot] = clamp_add(bytes_held[slot], badd);
			touched = 1'b1;
		end else if (used >= MAX_CLASSES) begin
			r.status = ST_TABLE_FULL;
		end else begin
			slot             = used;
			keys_held[slot]  = it.class_key;
			pages_held[slot] = padd;
			bytes_held[slot] = badd;
			used++;
			touched = 1'b1;
		end
		if (touched) begin
			r.class_pages = pages_held[slot];
			r.class_bytes = bytes_held[slot];
			total = clamp_add(total, padd);
			if (r.class_pages > lead_pages || (r.class_pages != '0 &&
				r.class_pages == lead_pages && slot < lead_slot)) begin
				lead_pages = r.class_pages;
				lead_key   = it.class_key;
				lead_slot  = slot;
			end
		end
		r.entries_used = ENTRY_W'(used);
		r.pages_total  = total;
		r.top_class    = lead_key;
		r.top_pages    = lead_pages;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used       = 0;
			total      = '0;
			lead_key   = '0;
			lead_pages = '0;
			lead_slot  = 0;
			due_results.delete();
			pending    = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (due_results.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: result transaction with none due: %p", $time, result);
				end else begin
					want = due_results.pop_front();
					if (result.status !== want.status ||
						result.entries_used !== want.entries_used ||
						result.class_pages !== want.class_pages ||
						result.class_bytes !== want.class_bytes ||
						result.pages_total !== want.pages_total ||
						result.top_class !== want.top_class ||
						result.top_pages !== want.top_pages) begin
						fails++;
						if (fails <= 10)
							$display({"%0t: mismatch (expected/actual) status %0d/%0d ",
								"entries %0d/%0d class_pages %h/%h class_bytes %h/%h ",
								"total %h/%h top_class %h/%h top_pages %h/%h"}, $time,
								want.status, result.status,
								want.entries_used, result.entries_used,
								want.class_pages, result.class_pages,
								want.class_bytes, result.class_bytes,
								want.pages_total, result.pages_total,
								want.top_class, result.top_class,
								want.top_pages, result.top_pages);
					end
				end
			end
			if (item_valid && !item_stall)
				due_results.push_back(tally(item));
			pending = due_results.size();
		end
	end

endmodule

/* dv/tb_bank_class_histogram.sv */
`timescale 1ns / 100ps
module tb_bank_class_histogram;
	import bch_pkg::*;

	localparam int CYCLE_LIMIT  = 5_000_000;
	localparam int RANDOM_ITEMS = 1000;
	localparam int SAT_ITEMS    = 22;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        item_valid   = 1'b0;
	logic        item_stall;
	bch_item_t   item         = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	bch_result_t result;

	int fails;
	int pending;
	int cycles     = 0;
	int stall_left = 0;
	bit calm       = 1'b0;

	logic [KEY_W-1:0] class_keys [$];

	always #5 clk = ~clk;

	bank_class_histogram DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	bank_class_histogram_checker hist_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.fails        (fails),
		.pending      (pending)
	);

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(20, 80);
	endfunction

	function automatic bch_item_t item_of(input logic [KEY_W-1:0] k,
		input logic [ADD_W-1:0] p, input logic [CNT_W-1:0] b);
		bch_item_t it;
		it.class_key = k;
		it.pages_add = p;
		it.bytes_add = b;
		return it;
	endfunction

	function automatic bch_item_t draw_item();
		bch_item_t   it;
		bit          fresh;
		logic [63:0] wide;
		fresh = (class_keys.size() == 0) || ($urandom_range(0, 99) < 22);
		if (fresh) begin
			case ($urandom_range(0, 5))
				0: it.class_key = '0;
				1: it.class_key = '1;
				2: it.class_key = (class_keys.size() != 0) ?
					class_keys[$urandom_range(0, class_keys.size() - 1)] ^
					(32'h1 << $urandom_range(0, 31)) : $urandom;
				default: it.class_key = $urandom;
			endcase
		end else begin
			it.class_key = class_keys[$urandom_range(0, class_keys.size() - 1)];
		end
		if ($urandom_range(0, 99) < 8) begin
			it.pages_add = '0;
			it.bytes_add = '0;
		end else begin
			case ($urandom_range(0, 9))
				0: it.pages_add = '0;
				1: it.pages_add = '1;
				2: it.pages_add = 32'h1 << $urandom_range(0, 31);
				3, 4: it.pages_add = $urandom;
				default: it.pages_add = $urandom_range(1, 1000);
			endcase
			wide = {$urandom, $urandom};
			case ($urandom_range(0, 9))
				0: it.bytes_add = '0;
				1: it.bytes_add = '1;
				2: it.bytes_add = 48'h1 << $urandom_range(0, 47);
				3, 4: it.bytes_add = wide[CNT_W-1:0];
				default: it.bytes_add = CNT_W'($urandom_range(1, 100000));
			endcase
		end
		if (fresh && (it.pages_add != '0 || it.bytes_add != '0) &&
			class_keys.size() < MAX_CLASSES)
			class_keys.push_back(it.class_key);
		return it;
	endfunction

	// entered and left just after a falling edge
	task automatic send_item(input bch_item_t it);
		int           gap;
		logic [127:0] junk;
		gap = calm ? 0 : pick_gap();
		repeat (gap) begin
			junk = {$urandom, $urandom, $urandom, $urandom};
			item_valid <= 1'b0;
			item       <= junk[$bits(bch_item_t)-1:0];
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (!arst_n || calm) begin
			result_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
		end else begin
			result_stall <= ($urandom_range(0, 99) < 35);
			stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("bank_class_histogram regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table lookup, zero-page entries, byte saturation, ties
		send_item(item_of(32'h0, 32'h0, 48'h0));
		send_item(item_of(32'h0, 32'h0, 48'h1));
		send_item(item_of(32'hFFFF_FFFF, 32'h0, 48'hFFFF_FFFF_FFFF));
		send_item(item_of(32'hFFFF_FFFF, 32'h0, 48'h1));
		send_item(item_of(32'h0, 32'h0, 48'h0));
		send_item(item_of(32'hA5A5_A5A5, 32'h5, 48'h0));
		send_item(item_of(32'h5A5A_5A5A, 32'h5, 48'h0));
		send_item(item_of(32'h5A5A_5A5A, 32'h1, 48'h0));
		send_item(item_of(32'hA5A5_A5A5, 32'h1, 48'h0));
		send_item(item_of(32'h0, 32'h6, 48'h0));
		send_item(item_of(32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'h0));
		send_item(item_of(32'h1234_5678, 32'h0, 48'h0));
		send_item(item_of(32'hFFFF_FFFE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
		send_item(item_of(32'h0000_0001, 32'h1, 48'h1));
		send_item(item_of(32'h8000_0000, 32'h8000_0000, 48'h8000_0000_0000));
		send_item(item_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF));

		repeat (RANDOM_ITEMS) begin
			if ($urandom_range(0, 149) == 0)
				calm = !calm;
			send_item(draw_item());
		end

		// full-scale adds to one class, its byte count pinned at the top
		calm = 1'b1;
		repeat (SAT_ITEMS) send_item(item_of(32'h0, '1, '1));
		calm = 1'b0;
		repeat (12) send_item(draw_item());

		item_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
		if (fails == 0)
			$display("bank_class_histogram regression: pass");
		else
			$display("bank_class_histogram regression: fail");
		$finish;
	end

endmodule
